// File: rtl/assert_macros.svh
// Assertion macros for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/y2i_pkg.sv
// Types and constants of the YUYV 4:2:2 to I420 converter.
package y2i_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int PAIR_LIMIT  = (STORE_DEPTH < 2048) ? STORE_DEPTH : 2048;
  localparam int ROW_LIMIT   = 4096;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 11;
  localparam int PIX_W     = 8;
  localparam int CHROMA_W  = 2 * PIX_W;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position of the pair being accepted.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_end;
  } pos_t;

endpackage

// File: rtl/y2i_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module y2i_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/y2i_pos.sv
// Configuration registers and row / pair column counters.
module y2i_pos import y2i_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 advance,
  output pos_t                 pos
);

  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] frame_height;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  logic [ROW_W-1:0] pairs;
  logic [CFG_W-1:0] rows;
  logic [ROW_W-1:0] pair_half;
  logic [CFG_W-1:0] row_even;
  logic             last_col;
  logic             last_row;

  // Clamp the configured geometry to what the counters and store hold.
  always_comb begin
    pair_half = line_width[CFG_W-1:1];
    if (pair_half == '0) begin
      pairs = ROW_W'(1);
    end else if (pair_half > ROW_W'(PAIR_LIMIT)) begin
      pairs = ROW_W'(PAIR_LIMIT);
    end else begin
      pairs = pair_half;
    end
    row_even = {frame_height[CFG_W-1:1], 1'b0};
    if (row_even < CFG_W'(2)) begin
      rows = CFG_W'(2);
    end else if (row_even > CFG_W'(ROW_LIMIT)) begin
      rows = CFG_W'(ROW_LIMIT);
    end else begin
      rows = row_even;
    end
    last_col = ({1'b0, col} + ROW_W'(1)) >= pairs;
    last_row = ({1'b0, row} + CFG_W'(1)) >= rows;
  end

  assign pos.row       = row;
  assign pos.col       = col;
  assign pos.frame_end = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_LINE_WIDTH:   line_width   <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (advance) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

// File: rtl/yuyv422_to_i420_converter.sv
// YUYV 4:2:2 to I420 converter: top level with line store and output stage.
// Takes one YUYV macropixel per clock unless stalled and returns one word per
// macropixel, registered in stage 1 then at the output, with both luma samples,
// the row and pair column, and on odd rows the truncated mean of the U and V
// from the row pair. Each word makes a single access to the chroma line store
// (a write on even rows, a read on odd rows), which sets the rate at one word
// per clock unless stalled; the store needs no clearing after reset. A stall on
// the output holds the pipeline and is passed back to the input in the same cycle.
`include "assert_macros.svh"
module yuyv422_to_i420_converter import y2i_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     luma_first,
  input  logic [PIX_W-1:0]     chroma_blue,
  input  logic [PIX_W-1:0]     luma_second,
  input  logic [PIX_W-1:0]     chroma_red,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ROW_W-1:0]     row_index,
  output logic [COL_W-1:0]     pair_column,
  output logic [PIX_W-1:0]     luma_left,
  output logic [PIX_W-1:0]     luma_right,
  output logic                 chroma_valid,
  output logic [PIX_W-1:0]     u_average,
  output logic [PIX_W-1:0]     v_average,
  output logic                 frame_end
);

  pos_t                pos;
  logic                accept;
  logic                advance;
  logic                odd_row;
  logic [CHROMA_W-1:0] store_rdata;

  logic                s1_valid;
  pos_t                s1_pos;
  logic [PIX_W-1:0]    s1_y0;
  logic [PIX_W-1:0]    s1_y1;
  logic [PIX_W-1:0]    s1_u;
  logic [PIX_W-1:0]    s1_v;
  logic [PIX_W:0]      u_sum;
  logic [PIX_W:0]      v_sum;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign odd_row  = pos.row[0];

  y2i_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .pos       (pos)
  );

  // Even rows park U/V; odd rows fetch them. Read data holds while stage 1 waits.
  y2i_ram #(
    .WIDTH (CHROMA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && !odd_row),
    .waddr (STORE_AW'(pos.col)),
    .wdata ({chroma_red, chroma_blue}),
    .re    (accept && odd_row),
    .raddr (STORE_AW'(pos.col)),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos <= pos;
      s1_y0  <= luma_first;
      s1_y1  <= luma_second;
      s1_u   <= chroma_blue;
      s1_v   <= chroma_red;
    end
  end

  assign u_sum = {1'b0, store_rdata[PIX_W-1:0]} + {1'b0, s1_u};
  assign v_sum = {1'b0, store_rdata[CHROMA_W-1:PIX_W]} + {1'b0, s1_v};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row_index    <= s1_pos.row;
      pair_column  <= s1_pos.col;
      luma_left    <= s1_y0;
      luma_right   <= s1_y1;
      chroma_valid <= s1_pos.row[0];
      u_average    <= s1_pos.row[0] ? u_sum[PIX_W:1] : '0;
      v_average    <= s1_pos.row[0] ? v_sum[PIX_W:1] : '0;
      frame_end    <= s1_pos.frame_end;
    end
  end

  `ASSERT_IMPLY(a_chroma_on_odd, clk, rst, out_valid, chroma_valid == row_index[0])
  `ASSERT_IMPLY(a_even_no_chroma, clk, rst, out_valid && !chroma_valid, (u_average == '0) && (v_average == '0))
  `ASSERT_IMPLY(a_stall_needs_item, clk, rst, in_stall, s1_valid && out_valid)

endmodule

// File: bench/tb.sv
// Self-checking bench for the YUYV 4:2:2 to I420 converter with stalls and register changes.
`timescale 1ns / 1ps
module tb import y2i_pkg::*;;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_PER_MODE = 400;

  typedef struct packed {
    logic [PIX_W-1:0] y0;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] y1;
    logic [PIX_W-1:0] v;
  } macropixel_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] luma_l;
    logic [PIX_W-1:0] luma_r;
    logic             chroma_ok;
    logic [PIX_W-1:0] u_avg;
    logic [PIX_W-1:0] v_avg;
    logic             last_pair;
  } pair_word_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     luma_first = '0;
  logic [PIX_W-1:0]     chroma_blue = '0;
  logic [PIX_W-1:0]     luma_second = '0;
  logic [PIX_W-1:0]     chroma_red = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROW_W-1:0]     row_index;
  logic [COL_W-1:0]     pair_column;
  logic [PIX_W-1:0]     luma_left;
  logic [PIX_W-1:0]     luma_right;
  logic                 chroma_valid;
  logic [PIX_W-1:0]     u_average;
  logic [PIX_W-1:0]     v_average;
  logic                 frame_end;

  yuyv422_to_i420_converter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .luma_first   (luma_first),
    .chroma_blue  (chroma_blue),
    .luma_second  (luma_second),
    .chroma_red   (chroma_red),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_index    (row_index),
    .pair_column  (pair_column),
    .luma_left    (luma_left),
    .luma_right   (luma_right),
    .chroma_valid (chroma_valid),
    .u_average    (u_average),
    .v_average    (v_average),
    .frame_end    (frame_end)
  );

  // Subsampler state as the bench sees it.
  logic [CFG_W-1:0]    line_width_reg = LINE_WIDTH_RESET;
  logic [CFG_W-1:0]    frame_height_reg = FRAME_HEIGHT_RESET;
  logic [CHROMA_W-1:0] chroma_row_store [STORE_DEPTH];
  logic [COL_W-1:0]    next_col = '0;
  logic [ROW_W-1:0]    next_row = '0;

  macropixel_t macropixels_pending [$];
  pair_word_t  pair_words_due [$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned holdoff_left = 0;
  logic        holdoff_start = 1'b0;
  int          mismatches = 0;
  int          words_checked = 0;
  int          chroma_words = 0;
  int          frames_done = 0;
  int          register_writes = 0;
  int          cycle_count = 0;

  function automatic int pairs_per_row(input logic [CFG_W-1:0] width);
    int p;
    p = int'(width) >> 1;
    if (p < 1) p = 1;
    if (p > PAIR_LIMIT) p = PAIR_LIMIT;
    return p;
  endfunction

  function automatic int rows_per_frame(input logic [CFG_W-1:0] height);
    int r;
    r = int'(height) & ~1;
    if (r < 2) r = 2;
    if (r > ROW_LIMIT) r = ROW_LIMIT;
    return r;
  endfunction

  // Produce the word for one macropixel and advance the raster position.
  function automatic pair_word_t subsample_pair(input macropixel_t px);
    pair_word_t w;
    logic [PIX_W:0] sum_u;
    logic [PIX_W:0] sum_v;
    logic last_col;
    logic last_row;
    last_col = (int'(next_col) + 1 >= pairs_per_row(line_width_reg));
    last_row = (int'(next_row) + 1 >= rows_per_frame(frame_height_reg));
    w.row = next_row;
    w.col = next_col;
    w.luma_l = px.y0;
    w.luma_r = px.y1;
    if (!next_row[0]) begin
      chroma_row_store[next_col] = {px.v, px.u};
      w.chroma_ok = 1'b0;
      w.u_avg = '0;
      w.v_avg = '0;
    end else begin
      sum_u = {1'b0, chroma_row_store[next_col][PIX_W-1:0]} + {1'b0, px.u};
      sum_v = {1'b0, chroma_row_store[next_col][CHROMA_W-1:PIX_W]} + {1'b0, px.v};
      w.chroma_ok = 1'b1;
      w.u_avg = sum_u[PIX_W:1];
      w.v_avg = sum_v[PIX_W:1];
    end
    w.last_pair = last_col && last_row;
    if (last_col) begin
      next_col = '0;
      next_row = last_row ? '0 : next_row + ROW_W'(1);
    end else begin
      next_col = next_col + COL_W'(1);
    end
    return w;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sender: hold a stalled word, otherwise offer the next one or idle.
  always @(posedge clk) begin : send
    macropixel_t px;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pair_words_due.push_back(subsample_pair({luma_first, chroma_blue,
                                                 luma_second, chroma_red}));
      end
      if (!in_valid || !in_stall) begin
        if (macropixels_pending.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          px = macropixels_pending.pop_front();
          luma_first  <= px.y0;
          chroma_blue <= px.u;
          luma_second <= px.y1;
          chroma_red  <= px.v;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input int expd, input int got);
    if (expd != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, expd, got);
      mismatches++;
    end
  endtask

  // Receiver: check each accepted word against the oldest one due.
  always @(posedge clk) begin : receive
    pair_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pair_words_due.size() == 0) begin
          $display("%0t: word with none due, expected nothing, got row %0d col %0d",
                   $time, row_index, pair_column);
          mismatches++;
        end else begin
          want = pair_words_due.pop_front();
          check_field("row_index", int'(want.row), int'(row_index));
          check_field("pair_column", int'(want.col), int'(pair_column));
          check_field("luma_left", int'(want.luma_l), int'(luma_left));
          check_field("luma_right", int'(want.luma_r), int'(luma_right));
          check_field("chroma_valid", int'(want.chroma_ok), int'(chroma_valid));
          check_field("u_average", int'(want.u_avg), int'(u_average));
          check_field("v_average", int'(want.v_avg), int'(v_average));
          check_field("frame_end", int'(want.last_pair), int'(frame_end));
          words_checked++;
          if (want.chroma_ok) chroma_words++;
          if (want.last_pair) frames_done++;
        end
      end
      out_stall <= (holdoff_left != 0) || ($urandom_range(99, 0) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (holdoff_start) begin
      holdoff_left <= HOLDOFF_CYCLES;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               pair_words_due.size());
      $display("[yuyv422_to_i420_converter] ERROR");
      $finish;
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] y0, u, y1, v);
    macropixels_pending.push_back({y0, u, y1, v});
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      push_pixel(PIX_W'($urandom_range(255, 0)), PIX_W'($urandom_range(255, 0)),
                 PIX_W'($urandom_range(255, 0)), PIX_W'($urandom_range(255, 0)));
    end
  endtask

  task automatic wait_drained();
    while (macropixels_pending.size() != 0 || in_valid || pair_words_due.size() != 0)
      @(negedge clk);
  endtask

  // Write one register once the block is idle. Widening during an odd row would
  // read store entries this row pair never wrote, so finish that row first.
  task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    int cur_pairs;
    wait_drained();
    cur_pairs = pairs_per_row(line_width_reg);
    if (idx == REG_LINE_WIDTH && next_row[0] && pairs_per_row(value) > cur_pairs) begin
      push_random((int'(next_col) + 1 >= cur_pairs) ? 1 : cur_pairs - int'(next_col));
      wait_drained();
    end
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_LINE_WIDTH) line_width_reg = value;
    else frame_height_reg = value;
    register_writes++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Four pairs per row, four rows: extremes of every byte and of the averages.
    write_register(REG_LINE_WIDTH, 13'd8);
    write_register(REG_FRAME_HEIGHT, 13'd4);
    push_pixel(8'h00, 8'h00, 8'hFF, 8'hFF);
    push_pixel(8'hFF, 8'hFF, 8'h00, 8'h00);
    push_pixel(8'h00, 8'hFF, 8'hFF, 8'h00);
    push_pixel(8'h55, 8'hAA, 8'hAA, 8'h55);
    push_pixel(8'hFF, 8'hFF, 8'h00, 8'h00);
    push_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h01, 8'hFE, 8'h80, 8'h01);
    push_pixel(8'hAA, 8'h55, 8'h55, 8'hAA);
    push_random(8);
    // Narrow the row mid-line: the column past the new end wraps at the next word.
    push_random(2);
    write_register(REG_LINE_WIDTH, 13'd2);
    push_random(4);
    // Shorten the frame while sitting on a row past its new end.
    push_random(3);
    write_register(REG_FRAME_HEIGHT, 13'd2);
    push_random(2);

    // Out-of-range width runs a long row until a narrow width cuts it short.
    write_register(REG_LINE_WIDTH, 13'h1FFF);
    push_random(40);
    write_register(REG_LINE_WIDTH, 13'd4);
    push_random(4);
    // Zero width with an out-of-range height: one pair per row, many rows.
    write_register(REG_LINE_WIDTH, 13'd0);
    write_register(REG_FRAME_HEIGHT, 13'h1FFF);
    push_random(40);

    // Long receiver hold-off while the sender keeps offering words.
    write_register(REG_LINE_WIDTH, 13'd12);
    write_register(REG_FRAME_HEIGHT, 13'd6);
    @(posedge clk);
    holdoff_start <= 1'b1;
    @(posedge clk);
    holdoff_start <= 1'b0;
    @(negedge clk);
    push_random(120);
    wait_drained();

    for (int mode = 0; mode < 4; mode++) begin
      wait_drained();
      case (mode)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
        default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < RANDOM_PER_MODE) begin
        if ($urandom_range(2, 0) == 0) begin
          if ($urandom_range(9, 0) != 0) begin
            write_register(REG_LINE_WIDTH, 13'(2 * $urandom_range(12, 1)));
          end else begin
            case ($urandom_range(4, 0))
              0: write_register(REG_LINE_WIDTH, 13'd0);
              1: write_register(REG_LINE_WIDTH, 13'd1);
              2: write_register(REG_LINE_WIDTH, 13'd7);
              3: write_register(REG_LINE_WIDTH, 13'h1FFF);
              default: write_register(REG_LINE_WIDTH, 13'd3);
            endcase
          end
        end
        if ($urandom_range(2, 0) == 0) begin
          if ($urandom_range(9, 0) != 0) begin
            write_register(REG_FRAME_HEIGHT, 13'(2 * $urandom_range(5, 1)));
          end else begin
            case ($urandom_range(3, 0))
              0: write_register(REG_FRAME_HEIGHT, 13'd0);
              1: write_register(REG_FRAME_HEIGHT, 13'd1);
              2: write_register(REG_FRAME_HEIGHT, 13'd5);
              default: write_register(REG_FRAME_HEIGHT, 13'h1FFF);
            endcase
          end
        end
        push_random($urandom_range(60, 8));
        sent += macropixels_pending.size();
        wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    $display("checked %0d words (%0d with averaged chroma), %0d frame ends, %0d register writes",
             words_checked, chroma_words, frames_done, register_writes);
    $display("mismatches: %0d, cycles: %0d", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("[yuyv422_to_i420_converter] OK");
    end else begin
      $display("[yuyv422_to_i420_converter] ERROR");
    end
    $finish;
  end

endmodule
